### rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// Stream buffer allocator package
// Shared state encoding and the request, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

	localparam logic [1:0] MODE_INIT  = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_FREE  = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT = 2'd1;
	localparam logic [1:0] STATUS_UNUSED = 2'd2;

	localparam logic REG_TOP   = 1'b0;
	localparam logic REG_FLOOR = 1'b1;

	localparam int          LEN_BITS       = 25;
	localparam logic [24:0] LEN_ALIGN_MASK = 25'd31;
	localparam logic [24:0] TOP_RESET      = 25'h1000000;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_QRD,
		S_QOUT,
		S_ASCAN_RD,
		S_ASCAN_CHK,
		S_ADEC,
		S_AUNLINK,
		S_APUSH,
		S_ARD,
		S_AOUT,
		S_AIDRD,
		S_AIDW,
		S_FRD,
		S_FCHK,
		S_FUNLINK,
		S_FPLACE,
		S_MRD,
		S_MCHK,
		S_RSTART,
		S_RRD,
		S_RCHK,
		S_RMOV,
		S_FEND,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

### rtl/sba_store.sv
// ----------------------------------------------------------------------------
// Stream buffer allocator slot store
// Per-slot link, address, capacity and length memories with registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_store #(
	parameter int SLOT_COUNT   = 64,
	parameter int ADDRESS_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] ra,
	output logic      [$clog2(SLOT_COUNT):0]   link_rd,
	output logic      [ADDRESS_BITS-1:0]       addr_rd,
	output logic      [24:0]                   cap_rd,
	output logic      [24:0]                   len_rd,
	input  wire logic                          link_clear,
	input  wire logic                          lwe,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] lwa,
	input  wire logic [$clog2(SLOT_COUNT):0]   lwd,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] dwa,
	input  wire logic                          dwe_addr,
	input  wire logic                          dwe_cap,
	input  wire logic                          dwe_len,
	input  wire logic [ADDRESS_BITS-1:0]       dw_addr,
	input  wire logic [24:0]                   dw_cap,
	input  wire logic [24:0]                   dw_len
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(SLOT_COUNT);

	logic [LW-1:0]           link_mem [SLOT_COUNT];
	logic [ADDRESS_BITS-1:0] addr_mem [SLOT_COUNT];
	logic [24:0]             cap_mem  [SLOT_COUNT];
	logic [24:0]             len_mem  [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   valid_q;
	logic [LW-1:0]           link_raw_q;
	logic                    rv_q;
	logic [SW-1:0]           ra_q;
	logic [LW-1:0]           link_dflt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (link_clear) begin
			valid_q <= '0;
		end else if (lwe) begin
			valid_q[lwa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lwe) begin
			link_mem[lwa] <= lwd;
		end
		if (dwe_addr) begin
			addr_mem[dwa] <= dw_addr;
		end
		if (dwe_cap) begin
			cap_mem[dwa] <= dw_cap;
		end
		if (dwe_len) begin
			len_mem[dwa] <= dw_len;
		end
		link_raw_q <= link_mem[ra];
		addr_rd    <= addr_mem[ra];
		cap_rd     <= cap_mem[ra];
		len_rd     <= len_mem[ra];
		rv_q       <= valid_q[ra];
		ra_q       <= ra;
	end

	// A link that was not written since init follows the initial chain.
	assign link_dflt = (32'(ra_q) == SLOT_COUNT - 1) ? NULL_LINK : LW'(ra_q) + LW'(1);
	assign link_rd   = rv_q ? link_raw_q : link_dflt;

endmodule

`default_nettype wire

### rtl/stream_buffer_allocator.sv
// ----------------------------------------------------------------------------
// Stream buffer allocator
// Best-fit free list allocator for buffer slots carved downward from a top
// address, walking its linked lists with one sequencer over a slot store.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_ready    mode, req_length, slot_id
//  out       out_valid / out_ready  status, granted_id, buffer_address,
//                                   buffer_length
//  config    cfg_we                 cfg_index, cfg_data
//
// Each list walk visits its nodes one by one, with a store read and a check per
// node and a move state for each free slot that returns to idle. Allocate
// scans the free list for the best fit, and a free of the lowest buffer walks
// the used and free lists after it has found its slot.
// The registered read of the slot store sets the read and check per node.
// Reset restores the initial lists at once; no clearing pass is needed.
// in_ready is low while an item is in work or its result waits on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_buffer_allocator #(
	parameter int SLOT_COUNT   = 64,
	parameter int ADDRESS_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [24:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [23:0] req_length,
	input  wire logic [5:0]  slot_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [5:0]       granted_id,
	output logic [23:0]      buffer_address,
	output logic [24:0]      buffer_length
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(SLOT_COUNT);
	localparam logic [24:0] ADDR_MAX = (ADDRESS_BITS >= 25) ? 25'h1FFFFFF :
		25'((64'd1 << ADDRESS_BITS) - 64'd1);
	localparam logic [24:0] LEN_ALIGN_MASK_C = sba_pkg::LEN_ALIGN_MASK;

	sba_pkg::state_t state_q, state_d;

	logic [24:0]             len_q;
	logic [5:0]              id_q;
	logic [24:0]             top_q, floor_q, sp_q;
	logic [LW-1:0]           used_head_q, free_head_q, idle_head_q;
	logic [LW-1:0]           cur_q, prev_q, best_q, best_prev_q, best_link_q;
	logic [24:0]             best_cap_q;
	logic                    have_q, any_q;
	logic [ADDRESS_BITS-1:0] min_q, faddr_q;
	logic [1:0]              st_q;
	logic [5:0]              gid_q;
	logic [23:0]             baddr_q;
	logic [24:0]             blen_q;

	logic [LW-1:0]           link_rd;
	logic [ADDRESS_BITS-1:0] addr_rd;
	logic [24:0]             cap_rd, len_rd;
	logic                    link_clear, lwe, dwe_addr, dwe_cap, dwe_len;
	logic [SW-1:0]           lwa, dwa;
	logic [LW-1:0]           lwd;

	logic [24:0] req_round;
	logic [24:0] start;
	logic        id_big;
	logic        alloc_fail;
	logic        exact_hit, better_hit, below_min;
	logic [LW-1:0] id_link;

	assign req_round  = (25'(req_length) + LEN_ALIGN_MASK_C) & ~LEN_ALIGN_MASK_C;
	assign start      = sp_q - len_q;
	assign id_big     = 32'(slot_id) >= SLOT_COUNT;
	assign id_link    = LW'(id_q);
	assign alloc_fail = (idle_head_q == NULL_LINK) || (sp_q < len_q) ||
		(start < floor_q) || (start > ADDR_MAX);
	assign exact_hit  = cap_rd == len_q;
	assign better_hit = (cap_rd > len_q) && (!have_q || cap_rd < best_cap_q);
	assign below_min  = !any_q || (addr_rd < min_q);

	sba_store #(
		.SLOT_COUNT  (SLOT_COUNT),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ra        (cur_q[SW-1:0]),
		.link_rd   (link_rd),
		.addr_rd   (addr_rd),
		.cap_rd    (cap_rd),
		.len_rd    (len_rd),
		.link_clear(link_clear),
		.lwe       (lwe),
		.lwa       (lwa),
		.lwd       (lwd),
		.dwa       (dwa),
		.dwe_addr  (dwe_addr),
		.dwe_cap   (dwe_cap),
		.dwe_len   (dwe_len),
		.dw_addr   (ADDRESS_BITS'(start)),
		.dw_cap    (len_q),
		.dw_len    (len_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sba_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (mode)
						sba_pkg::MODE_INIT:  state_d = sba_pkg::S_INIT;
						sba_pkg::MODE_ALLOC: state_d = (free_head_q == NULL_LINK) ?
							sba_pkg::S_ADEC : sba_pkg::S_ASCAN_RD;
						sba_pkg::MODE_FREE:  state_d = (id_big || used_head_q == NULL_LINK) ?
							sba_pkg::S_RESP : sba_pkg::S_FRD;
						sba_pkg::MODE_QUERY: state_d = id_big ? sba_pkg::S_RESP : sba_pkg::S_QRD;
						default:             state_d = sba_pkg::S_IDLE;
					endcase
				end
			end
			sba_pkg::S_INIT:      state_d = sba_pkg::S_RESP;
			sba_pkg::S_QRD:       state_d = sba_pkg::S_QOUT;
			sba_pkg::S_QOUT:      state_d = sba_pkg::S_RESP;
			sba_pkg::S_ASCAN_RD:  state_d = sba_pkg::S_ASCAN_CHK;
			sba_pkg::S_ASCAN_CHK: begin
				if (exact_hit || link_rd == NULL_LINK) begin
					state_d = sba_pkg::S_ADEC;
				end else begin
					state_d = sba_pkg::S_ASCAN_RD;
				end
			end
			sba_pkg::S_ADEC: begin
				if (have_q) begin
					state_d = sba_pkg::S_AUNLINK;
				end else if (alloc_fail) begin
					state_d = sba_pkg::S_RESP;
				end else begin
					state_d = sba_pkg::S_AIDRD;
				end
			end
			sba_pkg::S_AUNLINK:   state_d = sba_pkg::S_APUSH;
			sba_pkg::S_APUSH:     state_d = sba_pkg::S_ARD;
			sba_pkg::S_ARD:       state_d = sba_pkg::S_AOUT;
			sba_pkg::S_AOUT:      state_d = sba_pkg::S_RESP;
			sba_pkg::S_AIDRD:     state_d = sba_pkg::S_AIDW;
			sba_pkg::S_AIDW:      state_d = sba_pkg::S_RESP;
			sba_pkg::S_FRD:       state_d = sba_pkg::S_FCHK;
			sba_pkg::S_FCHK: begin
				if (cur_q == id_link) begin
					state_d = sba_pkg::S_FUNLINK;
				end else if (link_rd == NULL_LINK) begin
					state_d = sba_pkg::S_RESP;
				end else begin
					state_d = sba_pkg::S_FRD;
				end
			end
			sba_pkg::S_FUNLINK:   state_d = sba_pkg::S_FPLACE;
			sba_pkg::S_FPLACE: begin
				if (33'(faddr_q) != 33'(sp_q)) begin
					state_d = sba_pkg::S_RESP;
				end else if (used_head_q == NULL_LINK) begin
					state_d = sba_pkg::S_RSTART;
				end else begin
					state_d = sba_pkg::S_MRD;
				end
			end
			sba_pkg::S_MRD:       state_d = sba_pkg::S_MCHK;
			sba_pkg::S_MCHK:      state_d = (link_rd == NULL_LINK) ?
				sba_pkg::S_RSTART : sba_pkg::S_MRD;
			sba_pkg::S_RSTART:    state_d = (free_head_q == NULL_LINK) ?
				sba_pkg::S_FEND : sba_pkg::S_RRD;
			sba_pkg::S_RRD:       state_d = sba_pkg::S_RCHK;
			sba_pkg::S_RCHK: begin
				if (below_min) begin
					state_d = sba_pkg::S_RMOV;
				end else if (link_rd == NULL_LINK) begin
					state_d = sba_pkg::S_FEND;
				end else begin
					state_d = sba_pkg::S_RRD;
				end
			end
			sba_pkg::S_RMOV:      state_d = (best_link_q == NULL_LINK) ?
				sba_pkg::S_FEND : sba_pkg::S_RRD;
			sba_pkg::S_FEND:      state_d = sba_pkg::S_RESP;
			sba_pkg::S_RESP:      state_d = out_ready ? sba_pkg::S_IDLE : sba_pkg::S_RESP;
			default:              state_d = sba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == sba_pkg::S_IDLE;
		out_valid  = state_q == sba_pkg::S_RESP;
		link_clear = state_q == sba_pkg::S_INIT;
		lwe        = 1'b0;
		lwa        = cur_q[SW-1:0];
		lwd        = used_head_q;
		dwa        = cur_q[SW-1:0];
		dwe_addr   = 1'b0;
		dwe_cap    = 1'b0;
		dwe_len    = 1'b0;
		unique case (state_q)
			sba_pkg::S_AUNLINK: begin
				lwe = best_prev_q != NULL_LINK;
				lwa = best_prev_q[SW-1:0];
				lwd = best_link_q;
			end
			sba_pkg::S_APUSH: begin
				lwe     = 1'b1;
				lwa     = best_q[SW-1:0];
				lwd     = used_head_q;
				dwa     = best_q[SW-1:0];
				dwe_len = 1'b1;
			end
			sba_pkg::S_AIDW: begin
				lwe      = 1'b1;
				lwd      = used_head_q;
				dwe_addr = 1'b1;
				dwe_cap  = 1'b1;
				dwe_len  = 1'b1;
			end
			sba_pkg::S_FUNLINK: begin
				lwe = prev_q != NULL_LINK;
				lwa = prev_q[SW-1:0];
				lwd = best_link_q;
			end
			sba_pkg::S_FPLACE: begin
				lwe = 1'b1;
				lwa = id_link[SW-1:0];
				lwd = (33'(faddr_q) == 33'(sp_q)) ? idle_head_q : free_head_q;
			end
			sba_pkg::S_RCHK: begin
				lwe = below_min && (prev_q != NULL_LINK);
				lwa = prev_q[SW-1:0];
				lwd = link_rd;
			end
			sba_pkg::S_RMOV: begin
				lwe = 1'b1;
				lwd = idle_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sba_pkg::S_IDLE;
			top_q       <= sba_pkg::TOP_RESET;
			floor_q     <= '0;
			sp_q        <= sba_pkg::TOP_RESET;
			used_head_q <= NULL_LINK;
			free_head_q <= NULL_LINK;
			idle_head_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == sba_pkg::REG_TOP) begin
					top_q <= cfg_data;
				end else begin
					floor_q <= cfg_data;
				end
			end
			unique case (state_q)
				sba_pkg::S_INIT: begin
					used_head_q <= NULL_LINK;
					free_head_q <= NULL_LINK;
					idle_head_q <= '0;
					sp_q        <= top_q;
				end
				sba_pkg::S_AUNLINK: begin
					if (best_prev_q == NULL_LINK) begin
						free_head_q <= best_link_q;
					end
				end
				sba_pkg::S_APUSH:   used_head_q <= best_q;
				sba_pkg::S_AIDW: begin
					idle_head_q <= link_rd;
					used_head_q <= cur_q;
					sp_q        <= start;
				end
				sba_pkg::S_FUNLINK: begin
					if (prev_q == NULL_LINK) begin
						used_head_q <= best_link_q;
					end
				end
				sba_pkg::S_FPLACE: begin
					if (33'(faddr_q) == 33'(sp_q)) begin
						idle_head_q <= id_link;
					end else begin
						free_head_q <= id_link;
					end
				end
				sba_pkg::S_RCHK: begin
					if (below_min && prev_q == NULL_LINK) begin
						free_head_q <= link_rd;
					end
				end
				sba_pkg::S_RMOV:    idle_head_q <= cur_q;
				sba_pkg::S_FEND:    sp_q <= any_q ? 25'(min_q) : top_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sba_pkg::S_IDLE: begin
				len_q      <= req_round;
				id_q       <= slot_id;
				have_q     <= 1'b0;
				any_q      <= 1'b0;
				prev_q     <= NULL_LINK;
				st_q       <= sba_pkg::STATUS_OK;
				gid_q      <= '0;
				baddr_q    <= '0;
				blen_q     <= '0;
				cur_q      <= (mode == sba_pkg::MODE_ALLOC) ? free_head_q :
					(mode == sba_pkg::MODE_FREE) ? used_head_q : LW'(slot_id);
				if (mode == sba_pkg::MODE_FREE || mode == sba_pkg::MODE_QUERY) begin
					gid_q <= slot_id;
					if (id_big || (mode == sba_pkg::MODE_FREE && used_head_q == NULL_LINK)) begin
						st_q <= sba_pkg::STATUS_UNUSED;
					end
				end
			end
			sba_pkg::S_QOUT: begin
				baddr_q <= 24'(addr_rd);
				blen_q  <= len_rd;
			end
			sba_pkg::S_ASCAN_CHK: begin
				if (exact_hit || better_hit) begin
					best_q      <= cur_q;
					best_prev_q <= prev_q;
					best_link_q <= link_rd;
					best_cap_q  <= cap_rd;
					have_q      <= 1'b1;
				end
				prev_q <= cur_q;
				cur_q  <= link_rd;
			end
			sba_pkg::S_ADEC: begin
				cur_q <= idle_head_q;
				if (!have_q && alloc_fail) begin
					st_q <= sba_pkg::STATUS_NO_FIT;
				end
			end
			sba_pkg::S_APUSH:   cur_q <= best_q;
			sba_pkg::S_AOUT: begin
				gid_q   <= 6'(best_q);
				baddr_q <= 24'(addr_rd);
				blen_q  <= len_q;
			end
			sba_pkg::S_AIDW: begin
				gid_q   <= 6'(cur_q);
				baddr_q <= 24'(start);
				blen_q  <= len_q;
			end
			sba_pkg::S_FCHK: begin
				if (cur_q == id_link) begin
					best_link_q <= link_rd;
					faddr_q     <= addr_rd;
				end else begin
					prev_q <= cur_q;
					cur_q  <= link_rd;
					if (link_rd == NULL_LINK) begin
						st_q <= sba_pkg::STATUS_UNUSED;
					end
				end
			end
			sba_pkg::S_FPLACE:  cur_q <= used_head_q;
			sba_pkg::S_MCHK: begin
				if (below_min) begin
					min_q <= addr_rd;
				end
				any_q <= 1'b1;
				cur_q <= link_rd;
			end
			sba_pkg::S_RSTART: begin
				cur_q  <= free_head_q;
				prev_q <= NULL_LINK;
			end
			sba_pkg::S_RCHK: begin
				best_link_q <= link_rd;
				if (!below_min) begin
					prev_q <= cur_q;
					cur_q  <= link_rd;
				end
			end
			sba_pkg::S_RMOV:    cur_q <= best_link_q;
			default: begin
			end
		endcase
	end

	assign status         = st_q;
	assign granted_id     = gid_q;
	assign buffer_address = baddr_q;
	assign buffer_length  = blen_q;

endmodule

`default_nettype wire

### bench/tb_stream_buffer_allocator.sv
// ----------------------------------------------------------------------------
// Stream buffer allocator testbench
// Drives init, allocate, free and query items through the valid/ready input
// channel. A built-in best-fit allocator model works out each result as the
// item is accepted, and the monitor compares the results in order. The run
// steps through several top and floor address settings, with random idling
// on both sides, one long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stream_buffer_allocator;

	localparam int NSLOT = 64;
	localparam int NIL = 64;
	localparam int DRAIN = 450;
	localparam int WATCH_LIMIT = 5000;

	typedef struct {
		logic [1:0]  mode;
		logic [23:0] req;
		logic [5:0]  slot;
		bit          aim;
	} req_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  id;
		logic [23:0] addr;
		logic [24:0] len;
	} grant_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = sba_pkg::REG_TOP;
	logic [24:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  mode = sba_pkg::MODE_INIT;
	logic [23:0] req_length = '0;
	logic [5:0]  slot_id = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [5:0]  granted_id;
	logic [23:0] buffer_address;
	logic [24:0] buffer_length;

	stream_buffer_allocator dut (.*);

	req_item_t pending_q[$];
	grant_t    grants_due[$];
	int        errors = 0;
	int        accepted_in = 0;
	bit        rx_hold = 0;

	// Allocator model state.
	logic [24:0] top_addr = sba_pkg::TOP_RESET;
	logic [24:0] floor_addr = '0;
	int          link[NSLOT];
	logic [23:0] s_addr[NSLOT];
	logic [24:0] s_cap[NSLOT];
	logic [24:0] s_len[NSLOT];
	bit          s_written[NSLOT];
	int          used_head, free_head, idle_head;
	logic [24:0] sp;

	initial forever #4 clk = ~clk;

	function automatic void rebuild_lists();
		for (int i = 0; i < NSLOT; i++) begin
			link[i] = i + 1;
		end
		used_head = NIL;
		free_head = NIL;
		idle_head = 0;
		sp = top_addr;
	endfunction

	function automatic grant_t allocate(logic [23:0] req);
		grant_t r;
		logic [24:0] len;
		logic [24:0] start;
		logic [24:0] bcap;
		int s, prev, best, bprev, g;
		bit have;
		r = '{sba_pkg::STATUS_OK, 0, 0, 0};
		len = ({1'b0, req} + 25'd31) & ~sba_pkg::LEN_ALIGN_MASK;
		prev = NIL; best = NIL; bprev = NIL; have = 0; bcap = 0;
		s = free_head; g = 0;
		while (s < NSLOT && g < NSLOT) begin
			if (s_cap[s] == len) begin
				best = s; bprev = prev; have = 1;
				break;
			end
			if (s_cap[s] > len && (!have || s_cap[s] < bcap)) begin
				best = s; bprev = prev; bcap = s_cap[s]; have = 1;
			end
			prev = s;
			s = link[s];
			g++;
		end
		if (have) begin
			if (bprev < NSLOT) link[bprev] = link[best];
			else free_head = link[best];
			s_len[best] = len;
		end else begin
			if (idle_head >= NSLOT || sp < len) begin
				r.status = sba_pkg::STATUS_NO_FIT;
				return r;
			end
			start = sp - len;
			if (start < floor_addr || start[24]) begin
				r.status = sba_pkg::STATUS_NO_FIT;
				return r;
			end
			best = idle_head;
			idle_head = link[best];
			s_cap[best] = len;
			s_len[best] = len;
			s_addr[best] = start[23:0];
			s_written[best] = 1;
			sp = start;
		end
		link[best] = used_head;
		used_head = best;
		r.id = best[5:0];
		r.addr = s_addr[best];
		r.len = s_len[best];
		return r;
	endfunction

	function automatic grant_t release_slot(int id);
		grant_t r;
		int s, prev, nxt, g;
		bit found, any_used;
		logic [23:0] min_addr;
		r = '{sba_pkg::STATUS_UNUSED, id[5:0], 0, 0};
		prev = NIL; found = 0; any_used = 0; min_addr = 0;
		s = used_head; g = 0;
		while (s < NSLOT && g < NSLOT) begin
			if (s == id) begin
				found = 1;
				break;
			end
			prev = s;
			s = link[s];
			g++;
		end
		if (!found) return r;
		r.status = sba_pkg::STATUS_OK;
		if (prev < NSLOT) link[prev] = link[id];
		else used_head = link[id];
		if ({1'b0, s_addr[id]} == sp) begin
			link[id] = idle_head;
			idle_head = id;
			s = used_head; g = 0;
			while (s < NSLOT && g < NSLOT) begin
				if (!any_used || s_addr[s] < min_addr) min_addr = s_addr[s];
				any_used = 1;
				s = link[s];
				g++;
			end
			prev = NIL;
			s = free_head; g = 0;
			while (s < NSLOT && g < NSLOT) begin
				nxt = link[s];
				if (!any_used || s_addr[s] < min_addr) begin
					if (prev < NSLOT) link[prev] = link[s];
					else free_head = link[s];
					link[s] = idle_head;
					idle_head = s;
				end else begin
					prev = s;
				end
				s = nxt;
				g++;
			end
			sp = any_used ? {1'b0, min_addr} : top_addr;
		end else begin
			link[id] = free_head;
			free_head = id;
		end
		return r;
	endfunction

	function automatic grant_t predict_grant(req_item_t it);
		grant_t r;
		r = '{sba_pkg::STATUS_OK, 0, 0, 0};
		case (it.mode)
			sba_pkg::MODE_INIT: rebuild_lists();
			sba_pkg::MODE_ALLOC: r = allocate(it.req);
			sba_pkg::MODE_FREE: r = release_slot(int'(it.slot));
			default: r = '{sba_pkg::STATUS_OK, it.slot, s_addr[it.slot], s_len[it.slot]};
		endcase
		return r;
	endfunction

	// Resolves aimed frees; queries go to written slots, else to allocate.
	function automatic req_item_t settle(req_item_t it);
		int pool[$];
		int s, g;
		if (it.mode == sba_pkg::MODE_FREE && it.aim) begin
			s = used_head; g = 0;
			while (s < NSLOT && g < NSLOT) begin
				pool.push_back(s);
				s = link[s];
				g++;
			end
		end else if (it.mode == sba_pkg::MODE_QUERY && (it.aim || !s_written[it.slot])) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (s_written[i]) pool.push_back(i);
			end
			if (pool.size() == 0) it.mode = sba_pkg::MODE_ALLOC;
		end
		if (pool.size() > 0) it.slot = pool[$urandom_range(0, pool.size() - 1)];
		return it;
	endfunction

	always @(posedge clk) begin
		req_item_t it;
		bit quiet;
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) begin
				grants_due.push_back(predict_grant('{mode, req_length, slot_id, 0}));
				accepted_in++;
			end
			quiet = accepted_in > 500 && accepted_in < 700;
			if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
				it = settle(pending_q.pop_front());
				mode <= it.mode;
				req_length <= it.req;
				slot_id <= it.slot;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		grant_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("Unexpected result: status %0d id %0d",
						status, granted_id);
				end else begin
					e = grants_due.pop_front();
					if (status !== e.status || granted_id !== e.id ||
					    buffer_address !== e.addr || buffer_length !== e.len) begin
						errors++;
						if (errors <= 10) $display(
							"Mismatch: expected %0d/%0d/%h/%h, got %0d/%0d/%h/%h",
							e.status, e.id, e.addr, e.len,
							status, granted_id, buffer_address, buffer_length);
					end
				end
			end
			out_ready <= !rx_hold && ((accepted_in > 500 && accepted_in < 700) ||
				$urandom_range(0, 99) >= 34);
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
			else stuck++;
			if (stuck >= WATCH_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		wait (accepted_in >= 850);
		rx_hold = 1;
		repeat (600) @(posedge clk);
		rx_hold = 0;
	end

	task automatic push_item(logic [1:0] m, logic [23:0] r, logic [5:0] s, bit aim);
		pending_q.push_back('{m, r, s, aim});
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || in_valid || grants_due.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [24:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == sba_pkg::REG_TOP) top_addr = value;
		else floor_addr = value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_items(int n, int kmax);
		int p;
		logic [23:0] r;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 45) begin
				case ($urandom_range(0, 9))
					0, 1: r = $urandom_range(0, 4095);
					2: r = $urandom;
					default: r = 32 * $urandom_range(1, kmax) - $urandom_range(0, 31);
				endcase
				push_item(sba_pkg::MODE_ALLOC, r, 0, 0);
			end else if (p < 82) begin
				push_item(sba_pkg::MODE_FREE, 0, $urandom, $urandom_range(0, 4) != 0);
			end else if (p < 97) begin
				push_item(sba_pkg::MODE_QUERY, $urandom, $urandom, $urandom_range(0, 1));
			end else begin
				push_item(sba_pkg::MODE_INIT, $urandom, $urandom, 0);
			end
		end
	endtask

	task automatic run_phase(logic [24:0] t, logic [24:0] f, int n, int kmax);
		wait_drained();
		write_reg(sba_pkg::REG_TOP, t);
		write_reg(sba_pkg::REG_FLOOR, f);
		push_item(sba_pkg::MODE_INIT, 0, 0, 0);
		random_items(n, kmax);
	endtask

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			s_addr[i] = 0; s_cap[i] = 0; s_len[i] = 0; s_written[i] = 0;
		end
		rebuild_lists();
		repeat (12) @(posedge clk);
		arst_n <= 1;

		push_item(sba_pkg::MODE_INIT, 0, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd0, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'hFFFFFF, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd1, 0, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd5, 0);
		push_item(sba_pkg::MODE_QUERY, 0, 6'd0, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd0, 0);
		push_item(sba_pkg::MODE_INIT, 24'hFFFFFF, 6'h3F, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd100, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd64, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd200, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd32, 0, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd1, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd2, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd60, 0, 0);
		push_item(sba_pkg::MODE_ALLOC, 24'd33, 0, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd3, 0);
		push_item(sba_pkg::MODE_QUERY, 0, 6'd2, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd0, 0);
		push_item(sba_pkg::MODE_FREE, 0, 6'd0, 0);
		push_item(sba_pkg::MODE_QUERY, 0, 6'd3, 0);
		random_items(400, 24);

		run_phase(25'd4096, 25'd1024, 300, 8);
		run_phase(25'd0, 25'd0, 100, 8);
		run_phase(sba_pkg::TOP_RESET, sba_pkg::TOP_RESET, 100, 8);
		run_phase(25'd65536, 25'd0, 400, 24);
		run_phase(sba_pkg::TOP_RESET, 25'd0, 230, 24);

		wait_drained();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
rtl/sba_pkg.sv
rtl/sba_store.sv
rtl/stream_buffer_allocator.sv
bench/tb_stream_buffer_allocator.sv
